### rtl/hpm_pkg.sv
// ----------------------------------------------------------------------------
// Hilbert phase modulator package
// Shared sizes, register indexes, controller states and constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hpm_pkg;

    localparam int TAP_COUNT   = 49;
    localparam int SAMPLE_BITS = 16;
    localparam int CENTER      = (TAP_COUNT - 1) / 2;
    localparam int MAG_COUNT   = 12;
    localparam int MAG_USED    = ((CENTER + 1) / 2 < MAG_COUNT) ? (CENTER + 1) / 2 : MAG_COUNT;
    localparam int SLOT_BITS   = $clog2(TAP_COUNT);
    localparam int READ_COUNT  = 2 * MAG_USED + 1;
    localparam int K_BITS      = $clog2(READ_COUNT + 1);
    localparam int MAC_BITS    = SAMPLE_BITS + 17;
    localparam int CW          = (SAMPLE_BITS + 18 > 34) ? SAMPLE_BITS + 18 : 34;
    localparam int ZB          = 34;
    localparam int STEP_COUNT  = 28;
    localparam int STEP_BITS   = 5;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [31:0] K_INIT       = 32'd652032874;
    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BASE_STEP    = 3'd0,
        CFG_MIN_STEP     = 3'd1,
        CFG_MAX_STEP     = 3'd2,
        CFG_CARRIER_GAIN = 3'd3,
        CFG_MOD_GAIN     = 3'd4,
        CFG_MOD_INDEX    = 3'd5,
        CFG_MAX_INDEX    = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LIMIT,
        ST_MAC,
        ST_SIN_WAIT,
        ST_DEV1,
        ST_DEV2,
        ST_DEV3,
        ST_VEC_INIT,
        ST_VEC_RUN,
        ST_COS_INIT,
        ST_COS_RUN,
        ST_COS_DONE,
        ST_OUT_MUL,
        ST_OUT
    } state_t;

    function automatic logic [14:0] tap_mag(input int k);
        logic [14:0] m;
        case (k)
            0:       m = 15'd10430;
            1:       m = 15'd3169;
            2:       m = 15'd1812;
            3:       m = 15'd1199;
            4:       m = 15'd852;
            5:       m = 15'd632;
            6:       m = 15'd485;
            7:       m = 15'd383;
            8:       m = 15'd315;
            9:       m = 15'd265;
            10:      m = 15'd229;
            11:      m = 15'd203;
            default: m = 15'd0;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] atan_of(input logic [STEP_BITS-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000028;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/hpm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 49
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/hilbert_phase_modulator_core.sv
// ----------------------------------------------------------------------------
// Hilbert phase modulator core
// Forms the analytic signal of the input through a Hilbert FIR over a delay
// memory, shifts its phase by a sine modulator and outputs the cosine.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Direction
//  input     in_valid, in_stall, sample_in, ctl_*            in (stall out)
//  output    out_valid, out_stall, sample_out               out (stall in)
//  config    cfg_write, cfg_index, cfg_data                  in
//
// The shared 28-step CORDIC runs three times per transaction, or twice when
// the analytic signal is zero and the vectoring pass is skipped; the 25 reads
// of the delay memory run beside the first of those passes.
// Reset clears the delay line through per-entry valid bits, at once.
// A finished result waits in the output register while the next transaction
// is accepted; the core stalls only when that register is still full at the end.
`default_nettype none

module hilbert_phase_modulator_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [hpm_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic signed [15:0]                  ctl_freq,
    input  wire logic signed [15:0]                  ctl_carrier,
    input  wire logic signed [15:0]                  ctl_modulator,
    input  wire logic signed [15:0]                  ctl_index,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [hpm_pkg::SAMPLE_BITS-1:0]   sample_out,
    input  wire logic                                cfg_write,
    input  wire logic [hpm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [31:0]                         cfg_data
);

    import hpm_pkg::*;

    localparam int OUT_SHIFT = 31 - SAMPLE_BITS;
    localparam int OUT_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int OUT_MIN   = -(1 << (SAMPLE_BITS - 1));

    state_t state_reg, state_next;

    logic [31:0] base_reg, min_reg, max_reg;
    logic [15:0] cgain_reg, mgain_reg, mindex_reg, maxidx_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [15:0] cf_reg, cc_reg, cm_reg, ci_reg;

    logic [SLOT_BITS-1:0] slot_reg;
    logic [31:0]          phase_reg;
    logic [TAP_COUNT-1:0] valid_reg;

    logic signed [48:0] prodf_reg;
    logic signed [32:0] prodi_reg;
    logic [31:0] step_reg;
    logic [15:0] idx_reg;
    logic [16:0] car_reg, mg_reg;

    logic signed [34:0] step_sum, step_lo, step_clamped;
    logic signed [18:0] idx_sum, idx_lo, idx_clamped;
    logic signed [17:0] car_sum, mg_sum;

    logic [K_BITS-1:0]    k_reg;
    logic                 issue;
    int                   d_int, pos_int;
    logic [SLOT_BITS-1:0] raddr;
    logic signed [15:0]   tap_now;
    logic [SAMPLE_BITS-1:0] rdata;

    logic                   p1_v_reg, p1_center_reg, p1_ok_reg;
    logic signed [15:0]     p1_tap_reg;
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic                   p2_v_reg;
    logic signed [SAMPLE_BITS+15:0] prod_reg;
    logic signed [MAC_BITS-1:0]     acc_reg;
    logic signed [SAMPLE_BITS-1:0]  re_reg;
    logic                   mac_done;

    logic signed [CW-1:0] cor_x_reg, cor_y_reg, dx, dy;
    logic signed [ZB-1:0] cor_z_reg, atan_now;
    logic [STEP_BITS-1:0] cor_i_reg;
    logic                 cor_run_reg, cor_vec_reg, cor_flip_reg, up;

    logic signed [CW-1:0] re_ext, acc_ext;
    logic                 vec_zero;
    logic [31:0]          rot_ang, rot_a2;
    logic                 rot_flip;

    logic signed [CW-1:0] post_x, post_y, sh_x, sh_y;
    logic signed [16:0]   sin_now, cos_now;

    logic signed [16:0] sin_reg, cos_reg;
    logic [32:0]        m1_reg;
    logic signed [50:0] m2_reg;
    logic signed [32:0] m2_sh;
    logic signed [64:0] m3_reg;
    logic [31:0]        dev_reg, ang_reg;
    logic signed [34:0] outp_reg, out_sh;
    logic signed [SAMPLE_BITS-1:0] out_sat;
    logic               out_free;

    logic out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 32'd39370534;
            min_reg    <= 32'd89478;
            max_reg    <= 32'd1789569707;
            cgain_reg  <= 16'd32768;
            mgain_reg  <= 16'd32768;
            mindex_reg <= 16'd4096;
            maxidx_reg <= 16'd40960;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE_STEP:    base_reg   <= cfg_data;
                CFG_MIN_STEP:     min_reg    <= cfg_data;
                CFG_MAX_STEP:     max_reg    <= cfg_data;
                CFG_CARRIER_GAIN: cgain_reg  <= cfg_data[15:0];
                CFG_MOD_GAIN:     mgain_reg  <= cfg_data[15:0];
                CFG_MOD_INDEX:    mindex_reg <= cfg_data[15:0];
                CFG_MAX_INDEX:    maxidx_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    hpm_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(TAP_COUNT)
    ) u_delay_ram (
        .clk  (clk),
        .we   (state_reg == ST_PREP),
        .waddr(slot_reg),
        .wdata(sample_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        if (int'(k_reg) < MAG_USED)
        begin
            d_int   = CENTER - (2 * int'(k_reg) + 1);
            tap_now = -$signed({1'b0, tap_mag(int'(k_reg))});
        end
        else if (int'(k_reg) < 2 * MAG_USED)
        begin
            d_int   = CENTER + 2 * (int'(k_reg) - MAG_USED) + 1;
            tap_now = $signed({1'b0, tap_mag(int'(k_reg) - MAG_USED)});
        end
        else
        begin
            d_int   = CENTER;
            tap_now = 16'sd0;
        end
        pos_int = int'(slot_reg) - d_int;
        if (pos_int < 0)
        begin
            pos_int = pos_int + TAP_COUNT;
        end
        raddr = SLOT_BITS'(pos_int);
    end

    assign issue     = (state_reg == ST_MAC) && (int'(k_reg) < READ_COUNT);
    assign rd_sample = p1_ok_reg ? $signed(rdata) : '0;
    assign mac_done  = (int'(k_reg) >= READ_COUNT) && !p1_v_reg && !p2_v_reg;

    always_comb
    begin
        step_sum = $signed({3'b000, base_reg}) + 35'(prodf_reg >>> 15);
        step_lo  = (step_sum < $signed({3'b000, min_reg})) ? $signed({3'b000, min_reg})
                                                            : step_sum;
        step_clamped = (step_lo > $signed({3'b000, max_reg})) ? $signed({3'b000, max_reg})
                                                               : step_lo;
        idx_sum = $signed({3'b000, mindex_reg}) + 19'(prodi_reg >>> 15);
        idx_lo  = (idx_sum < 19'sd41) ? 19'sd41 : idx_sum;
        idx_clamped = (idx_lo > $signed({3'b000, maxidx_reg})) ? $signed({3'b000, maxidx_reg})
                                                                : idx_lo;
        car_sum = $signed({2'b00, cgain_reg}) + $signed({{2{cc_reg[15]}}, cc_reg});
        mg_sum  = $signed({2'b00, mgain_reg}) + $signed({{2{cm_reg[15]}}, cm_reg});
    end

    always_comb
    begin
        dx       = cor_y_reg >>> cor_i_reg;
        dy       = cor_x_reg >>> cor_i_reg;
        atan_now = $signed({2'b00, atan_of(cor_i_reg)});
        up       = cor_vec_reg ? !(cor_y_reg > 0) : !cor_z_reg[ZB-1];
        re_ext   = CW'(re_reg) <<< 15;
        acc_ext  = CW'(acc_reg);
        vec_zero = (re_reg == '0) && (acc_reg == '0);
        rot_ang  = (state_reg == ST_LIMIT) ? phase_reg : (ang_reg + dev_reg);
        rot_flip = rot_ang[31] ^ rot_ang[30];
        rot_a2   = rot_flip ? (rot_ang - 32'h80000000) : rot_ang;
        post_x   = cor_flip_reg ? -cor_x_reg : cor_x_reg;
        post_y   = cor_flip_reg ? -cor_y_reg : cor_y_reg;
        sh_x     = post_x >>> 15;
        sh_y     = post_y >>> 15;
        if (sh_x > CW'(32768))
            cos_now = 17'sd32767 + 17'sd1;
        else if (sh_x < -CW'(32768))
            cos_now = -17'sd32767 - 17'sd1;
        else
            cos_now = 17'(sh_x);
        if (sh_y > CW'(32768))
            sin_now = 17'sd32767 + 17'sd1;
        else if (sh_y < -CW'(32768))
            sin_now = -17'sd32767 - 17'sd1;
        else
            sin_now = 17'(sh_y);
        m2_sh  = 33'(m2_reg >>> 18);
        out_sh = outp_reg >>> OUT_SHIFT;
        if (out_sh > 35'(OUT_MAX))
            out_sat = SAMPLE_BITS'(OUT_MAX);
        else if (out_sh < 35'(OUT_MIN))
            out_sat = SAMPLE_BITS'(OUT_MIN);
        else
            out_sat = SAMPLE_BITS'(out_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_PREP;
            ST_PREP:     state_next = ST_LIMIT;
            ST_LIMIT:    state_next = ST_MAC;
            ST_MAC:      if (mac_done) state_next = ST_SIN_WAIT;
            ST_SIN_WAIT: if (!cor_run_reg) state_next = ST_DEV1;
            ST_DEV1:     state_next = ST_DEV2;
            ST_DEV2:     state_next = ST_DEV3;
            ST_DEV3:     state_next = ST_VEC_INIT;
            ST_VEC_INIT: state_next = vec_zero ? ST_COS_INIT : ST_VEC_RUN;
            ST_VEC_RUN:  if (!cor_run_reg) state_next = ST_COS_INIT;
            ST_COS_INIT: state_next = ST_COS_RUN;
            ST_COS_RUN:  if (!cor_run_reg) state_next = ST_COS_DONE;
            ST_COS_DONE: state_next = ST_OUT_MUL;
            ST_OUT_MUL:  state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            phase_reg     <= '0;
            valid_reg     <= '0;
            k_reg         <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            cor_run_reg   <= 1'b0;
            cor_i_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg && !p1_center_reg;
            if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == ST_PREP)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (state_reg == ST_LIMIT)
            begin
                k_reg <= '0;
            end
            if (cor_run_reg)
            begin
                cor_i_reg <= cor_i_reg + 1'b1;
                if (int'(cor_i_reg) == STEP_COUNT - 1)
                begin
                    cor_run_reg <= 1'b0;
                end
            end
            if (state_reg == ST_LIMIT || state_reg == ST_COS_INIT ||
                (state_reg == ST_VEC_INIT && !vec_zero))
            begin
                cor_run_reg <= 1'b1;
                cor_i_reg   <= '0;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_reg + step_reg;
                slot_reg      <= (int'(slot_reg) >= TAP_COUNT - 1) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            sample_reg <= sample_in;
            cf_reg     <= ctl_freq;
            cc_reg     <= ctl_carrier;
            cm_reg     <= ctl_modulator;
            ci_reg     <= ctl_index;
        end
        if (state_reg == ST_PREP)
        begin
            prodf_reg <= cf_reg * $signed({1'b0, base_reg});
            prodi_reg <= ci_reg * $signed({1'b0, mindex_reg});
        end
        if (state_reg == ST_LIMIT)
        begin
            step_reg <= step_clamped[31:0];
            idx_reg  <= idx_clamped[15:0];
            car_reg  <= (car_sum < 0) ? 17'd0 : (car_sum > 18'sd32768) ? 17'd32768
                                                                        : car_sum[16:0];
            mg_reg   <= (mg_sum < 0) ? 17'd0 : (mg_sum > 18'sd32768) ? 17'd32768
                                                                     : mg_sum[16:0];
            acc_reg  <= '0;
        end

        p1_tap_reg    <= tap_now;
        p1_center_reg <= (int'(k_reg) == READ_COUNT - 1);
        p1_ok_reg     <= valid_reg[raddr];
        if (p1_v_reg)
        begin
            if (p1_center_reg)
                re_reg <= rd_sample;
            else
                prod_reg <= p1_tap_reg * rd_sample;
        end
        if (p2_v_reg)
        begin
            acc_reg <= acc_reg + MAC_BITS'(prod_reg);
        end

        if (cor_run_reg)
        begin
            if (up)
            begin
                cor_x_reg <= cor_x_reg - dx;
                cor_y_reg <= cor_y_reg + dy;
                cor_z_reg <= cor_z_reg - atan_now;
            end
            else
            begin
                cor_x_reg <= cor_x_reg + dx;
                cor_y_reg <= cor_y_reg - dy;
                cor_z_reg <= cor_z_reg + atan_now;
            end
        end
        if (state_reg == ST_LIMIT || state_reg == ST_COS_INIT)
        begin
            cor_vec_reg  <= 1'b0;
            cor_flip_reg <= rot_flip;
            cor_x_reg    <= CW'(K_INIT);
            cor_y_reg    <= '0;
            cor_z_reg    <= ZB'($signed(rot_a2));
        end
        if (state_reg == ST_VEC_INIT)
        begin
            cor_vec_reg  <= 1'b1;
            cor_flip_reg <= 1'b0;
            if (re_ext < 0)
            begin
                cor_x_reg <= -re_ext;
                cor_y_reg <= -acc_ext;
                cor_z_reg <= ZB'(35'h080000000);
            end
            else
            begin
                cor_x_reg <= re_ext;
                cor_y_reg <= acc_ext;
                cor_z_reg <= '0;
            end
            if (vec_zero)
            begin
                ang_reg <= '0;
            end
        end
        if (state_reg == ST_VEC_RUN && !cor_run_reg)
        begin
            ang_reg <= cor_z_reg[31:0];
        end

        if (state_reg == ST_SIN_WAIT && !cor_run_reg)
        begin
            sin_reg <= sin_now;
        end
        if (state_reg == ST_DEV1)
        begin
            m1_reg <= idx_reg * mg_reg;
        end
        if (state_reg == ST_DEV2)
        begin
            m2_reg <= $signed({1'b0, m1_reg}) * sin_reg;
        end
        if (state_reg == ST_DEV3)
        begin
            m3_reg <= m2_sh * $signed(TURN_PER_RAD);
        end
        if (state_reg == ST_VEC_INIT)
        begin
            dev_reg <= m3_reg[55:24];
        end
        if (state_reg == ST_COS_DONE)
        begin
            cos_reg <= cos_now;
        end
        if (state_reg == ST_OUT_MUL)
        begin
            outp_reg <= $signed({1'b0, car_reg}) * cos_reg;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            sample_out_reg <= out_sat;
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(slot_reg) < TAP_COUNT)
        else $error("write slot out of range");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_PREP))
        else $error("accepted transaction did not start");

    a_idle_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cor_run_reg)
        else $error("CORDIC busy while idle");

    a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
        cor_run_reg |-> (int'(cor_i_reg) < STEP_COUNT))
        else $error("CORDIC step count overrun");

    a_issue_only_mac: assert property (@(posedge clk) disable iff (!rst_n)
        p1_v_reg |-> ($past(state_reg) == ST_MAC))
        else $error("delay read outside filter pass");

endmodule

`default_nettype wire

### verif/hilbert_phase_modulator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hilbert phase modulator core testbench
// Drives directed and random samples with control values through the core
// under several register settings and random idling on both channels, and
// checks every output sample against a known result or a cycle-free modulator model.
// ----------------------------------------------------------------------------
module hilbert_phase_modulator_core_test;
    import hpm_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 600;
    localparam int DIRECTED_COUNT = 15;

    typedef struct {
        logic signed [15:0] smp;
        logic signed [15:0] cf;
        logic signed [15:0] cc;
        logic signed [15:0] cm;
        logic signed [15:0] ci;
        bit known;
        logic signed [15:0] res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [15:0] ctl_freq;
    logic signed [15:0] ctl_carrier;
    logic signed [15:0] ctl_modulator;
    logic signed [15:0] ctl_index;
    logic out_valid;
    logic out_stall;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0] cfg_data;

    bit [31:0] m_base, m_min, m_max;
    bit [15:0] m_car_gain, m_mod_gain, m_index, m_max_index;
    longint m_line [TAP_COUNT];
    int m_slot;
    bit [31:0] m_phase;

    logic signed [15:0] expected_samples [$];
    int errors;
    int samples_sent;
    int samples_checked;
    int cycles;
    int idle_mode;
    bit hold_req;

    hilbert_phase_modulator_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .ctl_freq(ctl_freq),
        .ctl_carrier(ctl_carrier),
        .ctl_modulator(ctl_modulator),
        .ctl_index(ctl_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("hilbert_phase_modulator_core verification failed");
            $finish;
        end
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic bit [31:0] carrier_angle(input longint x, input longint y);
        bit [31:0] a;
        longint dx, dy;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            a = 32'h80000000;
        end
        for (int i = 0; i < STEP_COUNT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                a += atan_of(STEP_BITS'(i));
            end
            else
            begin
                x -= dx;
                y += dy;
                a -= atan_of(STEP_BITS'(i));
            end
        end
        return a;
    endfunction

    task automatic rotate(input bit [31:0] ang, output longint co, output longint si);
        bit flip;
        longint x, y, z, dx, dy;
        flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
        x = 652032874;
        y = 0;
        if (flip)
            ang -= 32'h80000000;
        z = longint'(ang);
        if (ang[31])
            z = z - 64'h1_0000_0000;
        for (int i = 0; i < STEP_COUNT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_of(STEP_BITS'(i)));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_of(STEP_BITS'(i)));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        co = clip(x >>> 15, -32768, 32768);
        si = clip(y >>> 15, -32768, 32768);
    endtask

    task automatic modulate(input stim_row_t r, output logic signed [15:0] res);
        longint step, car, mg, idx, acc, re, s, c, unused, dev, v, tap;
        int pos, m;
        bit [31:0] ang;
        step = longint'(m_base) + ((longint'(r.cf) * longint'(m_base)) >>> 15);
        step = clip(step, longint'(m_min), longint'(m_max));
        car = clip(longint'(m_car_gain) + longint'(r.cc), 0, 32768);
        mg = clip(longint'(m_mod_gain) + longint'(r.cm), 0, 32768);
        idx = longint'(m_index) + ((longint'(r.ci) * longint'(m_index)) >>> 15);
        idx = clip(idx, 41, longint'(m_max_index));
        m_line[m_slot] = longint'(r.smp);
        acc = 0;
        for (int d = 0; d < TAP_COUNT; d++)
        begin
            m = (d > CENTER) ? d - CENTER : CENTER - d;
            tap = 0;
            if (m % 2 == 1 && (m - 1) / 2 < MAG_COUNT)
                tap = (d > CENTER) ? longint'(tap_mag((m - 1) / 2))
                                   : -longint'(tap_mag((m - 1) / 2));
            pos = m_slot - d;
            if (pos < 0)
                pos += TAP_COUNT;
            acc += tap * m_line[pos];
        end
        pos = m_slot - CENTER;
        if (pos < 0)
            pos += TAP_COUNT;
        re = m_line[pos] * 32768;
        ang = carrier_angle(re, acc);
        rotate(m_phase, unused, s);
        dev = (((idx * mg * s) >>> 18) * longint'(TURN_PER_RAD)) >>> 24;
        ang += dev[31:0];
        rotate(ang, c, unused);
        v = clip((car * c) >>> (31 - SAMPLE_BITS), -32768, 32767);
        res = v[15:0];
        m_phase += step[31:0];
        m_slot = (m_slot + 1 >= TAP_COUNT) ? 0 : m_slot + 1;
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("Mismatch at cycle %0d: %s", cycles, what);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_BASE_STEP:    m_base = val;
            CFG_MIN_STEP:     m_min = val;
            CFG_MAX_STEP:     m_max = val;
            CFG_CARRIER_GAIN: m_car_gain = val[15:0];
            CFG_MOD_GAIN:     m_mod_gain = val[15:0];
            CFG_MOD_INDEX:    m_index = val[15:0];
            CFG_MAX_INDEX:    m_max_index = val[15:0];
            default:          ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_sample(input stim_row_t r);
        logic signed [15:0] res;
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 28 : (idle_mode == 1) ? 63 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= r.smp;
        ctl_freq <= r.cf;
        ctl_carrier <= r.cc;
        ctl_modulator <= r.cm;
        ctl_index <= r.ci;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        modulate(r, res);
        expected_samples.push_back(r.known ? r.res : res);
        samples_sent++;
    endtask

    function automatic logic signed [15:0] rand_ctl();
        case ($urandom_range(9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3, 4: return 16'($urandom);
            default: return 16'sd0;
        endcase
    endfunction

    task automatic load_setting(input int p);
        case (p)
            0:
            begin
                write_reg(CFG_BASE_STEP, 32'd39370534);
                write_reg(CFG_MIN_STEP, 32'd89478);
                write_reg(CFG_MAX_STEP, 32'd1789569707);
                write_reg(CFG_CARRIER_GAIN, 32'd32768);
                write_reg(CFG_MOD_GAIN, 32'd32768);
                write_reg(CFG_MOD_INDEX, 32'd4096);
                write_reg(CFG_MAX_INDEX, 32'd40960);
            end
            1:
            begin
                write_reg(CFG_BASE_STEP, 32'hFFFFFFFF);
                write_reg(CFG_MIN_STEP, 32'd0);
                write_reg(CFG_MAX_STEP, 32'hFFFFFFFF);
                write_reg(CFG_CARRIER_GAIN, 32'hFFFF);
                write_reg(CFG_MOD_GAIN, 32'hFFFF);
                write_reg(CFG_MOD_INDEX, 32'hFFFF);
                write_reg(CFG_MAX_INDEX, 32'hFFFF);
            end
            2:
            begin
                write_reg(CFG_BASE_STEP, 32'd0);
                write_reg(CFG_MIN_STEP, 32'h90000000);
                write_reg(CFG_MAX_STEP, 32'h10000000);
                write_reg(CFG_CARRIER_GAIN, 32'd0);
                write_reg(CFG_MOD_GAIN, 32'd0);
                write_reg(CFG_MOD_INDEX, 32'd0);
                write_reg(CFG_MAX_INDEX, 32'd41);
                write_reg(CFG_UNUSED, 32'hFFFFFFFF);
            end
            default:
            begin
                write_reg(CFG_BASE_STEP, $urandom);
                write_reg(CFG_MIN_STEP, $urandom_range(32'h00100000));
                write_reg(CFG_MAX_STEP, $urandom_range(32'hFFFFFFFF, 32'h20000000));
                write_reg(CFG_CARRIER_GAIN, $urandom_range(40000));
                write_reg(CFG_MOD_GAIN, $urandom_range(40000));
                write_reg(CFG_MOD_INDEX, $urandom_range(65535));
                write_reg(CFG_MAX_INDEX, $urandom_range(65535, 41));
                write_reg(CFG_UNUSED, $urandom);
            end
        endcase
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (idle_mode == 0)
                out_stall <= ($urandom_range(99) < 63);
            else if (idle_mode == 1)
                out_stall <= ($urandom_range(99) < 28);
            else
                out_stall <= 1'b0;
            @(negedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected sample_out %0d", sample_out));
                else if (sample_out !== expected_samples[0])
                    report_mismatch($sformatf("sample_out %0d, expected %0d",
                                              sample_out, expected_samples[0]));
                if (expected_samples.size() != 0)
                    void'(expected_samples.pop_front());
                samples_checked++;
            end
        end
    end

    initial
    begin
        stim_row_t row;
        static stim_row_t directed [DIRECTED_COUNT] = '{
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
            '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b1, 16'sd0},
            '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b1, 16'sd0},
            '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
            '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 16'sd0},
            '{-16'sd32768, -16'sd32768, 16'sd0, -16'sd32768, -16'sd32768, 1'b0, 16'sd0},
            '{16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 16'sd0},
            '{-16'sd1, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 16'sd0},
            '{16'sd12345, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
            '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 16'sd0},
            '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 16'sd0},
            '{16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
            '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
            '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0}
        };
        errors = 0;
        samples_sent = 0;
        samples_checked = 0;
        cycles = 0;
        idle_mode = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        ctl_freq = '0;
        ctl_carrier = '0;
        ctl_modulator = '0;
        ctl_index = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_BASE_STEP;
        cfg_data = '0;
        m_base = 32'd39370534;
        m_min = 32'd89478;
        m_max = 32'd1789569707;
        m_car_gain = 16'd32768;
        m_mod_gain = 16'd32768;
        m_index = 16'd4096;
        m_max_index = 16'd40960;
        foreach (m_line[i])
            m_line[i] = 0;
        m_slot = 0;
        m_phase = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_sample(directed[i]);
        for (int i = 0; i < 10; i++)
        begin
            row = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0};
            send_sample(row);
        end
        for (int p = 0; p < 6; p++)
        begin
            idle_mode = p / 2;
            in_valid <= 1'b0;
            wait_drained();
            load_setting(p);
            for (int i = 0; i < 90; i++)
            begin
                if (p == 1 && i == 10)
                    hold_req = 1'b1;
                if (p == 3 && i == 45)
                begin
                    in_valid <= 1'b0;
                    while (expected_samples.size() != 0)
                        @(posedge clk);
                end
                row.smp = 16'($urandom);
                row.cf = rand_ctl();
                row.cc = rand_ctl();
                row.cm = rand_ctl();
                row.ci = rand_ctl();
                row.known = 1'b0;
                row.res = 16'sd0;
                send_sample(row);
            end
        end
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples, checked %0d outputs over six register settings,",
                 samples_sent, samples_checked);
        $display("with idling on both channels and a long output hold; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("hilbert_phase_modulator_core verification clean");
        else
            $display("hilbert_phase_modulator_core verification failed");
        $finish;
    end

endmodule
